// ----- design/wsts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wsts_pkg;

    localparam int CFG_W   = 7;
    localparam int IDX_IN_W = 6;
    localparam int FRAC_W  = 32;
    localparam int RATE_W  = 32;
    localparam int CNT_W   = 16;
    localparam int COEF_W  = 2;
    localparam int SUM_W   = 54;
    // running interval start during a walk, kept wide so it never wraps
    localparam int START_W = 64;
    localparam int FACT_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic FUNC_SEARCH = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic                func;
        logic [IDX_IN_W-1:0] reaction_index;
        logic [FRAC_W-1:0]   rand_fraction;
        logic [RATE_W-1:0]   rate;
        logic [CNT_W-1:0]    count_first;
        logic [COEF_W-1:0]   coeff_first;
        logic [CNT_W-1:0]    count_second;
        logic [COEF_W-1:0]   coeff_second;
    } in_item_t;

    typedef struct packed {
        logic [IDX_IN_W-1:0] selected_index;
        logic                found;
        logic [SUM_W-1:0]    total_propensity;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/wsts_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsts_row_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 156,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/wsts_prop_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsts_prop_unit #(
    parameter int PROP_WIDTH = 48
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire wsts_pkg::in_item_t  item,
    output logic                     ready,
    output logic [PROP_WIDTH-1:0]    prop
);

    localparam int HALF  = (PROP_WIDTH + 1) / 2;
    localparam int HI_W  = PROP_WIDTH - HALF;
    localparam int LO_PW = HALF + wsts_pkg::FACT_W;
    localparam int HI_PW = HI_W + wsts_pkg::FACT_W;
    localparam int FULL_W = PROP_WIDTH + wsts_pkg::FACT_W;
    localparam logic [2:0] LAST_SLOT = 3'd6;
    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_SAT = 2'd2;

    logic                     run_reg;
    logic                     ready_reg;
    logic [2:0]               slot_reg;
    logic [1:0]               phase_reg;
    logic [PROP_WIDTH-1:0]    p_reg;
    logic [LO_PW-1:0]         lo_reg;
    logic [HI_PW-1:0]         hi_reg;
    wsts_pkg::in_item_t       item_reg;
    logic [wsts_pkg::FACT_W-1:0] factor;
    logic [FULL_W-1:0]        full;

    // one falling-factorial term: c - i when the term is present, else one
    function automatic logic [wsts_pkg::FACT_W-1:0] ff_term(
        input logic [wsts_pkg::CNT_W-1:0]  c,
        input logic [wsts_pkg::COEF_W-1:0] k,
        input logic [1:0]                  i
    );
        logic [wsts_pkg::CNT_W-1:0] ci;
        ci = wsts_pkg::CNT_W'(i);
        if (k <= i)
            return wsts_pkg::FACT_W'(1);
        else if (c >= ci)
            return wsts_pkg::FACT_W'(c - ci);
        else
            return '0;
    endfunction

    always_comb
    begin
        unique case (slot_reg)
            3'd0:    factor = item_reg.rate;
            3'd1:    factor = ff_term(item_reg.count_first, item_reg.coeff_first, 2'd0);
            3'd2:    factor = ff_term(item_reg.count_first, item_reg.coeff_first, 2'd1);
            3'd3:    factor = ff_term(item_reg.count_first, item_reg.coeff_first, 2'd2);
            3'd4:    factor = ff_term(item_reg.count_second, item_reg.coeff_second, 2'd0);
            3'd5:    factor = ff_term(item_reg.count_second, item_reg.coeff_second, 2'd1);
            3'd6:    factor = ff_term(item_reg.count_second, item_reg.coeff_second, 2'd2);
            default: factor = wsts_pkg::FACT_W'(1);
        endcase
        full = ({hi_reg, {HALF{1'b0}}}) + FULL_W'(lo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            ready_reg <= 1'b0;
            slot_reg  <= '0;
            phase_reg <= PH_LO;
        end
        else
        begin
            ready_reg <= 1'b0;
            if (go)
            begin
                run_reg   <= 1'b1;
                slot_reg  <= '0;
                phase_reg <= PH_LO;
            end
            else if (run_reg)
            begin
                if (phase_reg == PH_SAT)
                begin
                    phase_reg <= PH_LO;
                    slot_reg  <= slot_reg + 3'd1;
                    if (slot_reg == LAST_SLOT)
                    begin
                        run_reg   <= 1'b0;
                        ready_reg <= 1'b1;
                    end
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
        end
    end

    // saturating product, one partial product per cycle
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            item_reg <= item;
            p_reg    <= PROP_WIDTH'(1);
        end
        else if (run_reg)
        begin
            unique case (phase_reg)
                PH_LO:   lo_reg <= LO_PW'(p_reg[HALF-1:0]) * LO_PW'(factor);
                PH_HI:   hi_reg <= HI_PW'(p_reg[PROP_WIDTH-1:HALF]) * HI_PW'(factor);
                PH_SAT:  p_reg  <= (|full[FULL_W-1:PROP_WIDTH]) ? {PROP_WIDTH{1'b1}}
                                                                 : full[PROP_WIDTH-1:0];
                default: p_reg  <= p_reg;
            endcase
        end
    end

    assign ready = ready_reg;
    assign prop  = p_reg;

endmodule

`default_nettype wire

// ----- design/weighted_sum_tree_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// weighted selection over reaction propensities held in an implicit binary sum tree
// command channel: an item is taken at a clock edge with start high and busy low;
//   func selects update (recompute one propensity, push the change to the root)
//   or search (scale rand_fraction by the total and walk down to a reaction)
// result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so every result must be taken in that cycle
// config channel: cfg_valid/cfg_ready write reactions_in_use; cfg_ready is always
//   high, and the register should only be written while busy is low
// one item at a time; all tree state lives in one row memory (propensity, left
//   and right subtree sum per node) with a registered read
// update: the saturating multiply over seven factors in the propensity unit
//   dominates, followed by one read-modify-write per level up to the root
// update of a node outside the tree: the tree is left unchanged and the total is read
// search: one read-add-compare per level of the walk
// reset: the memory is swept to zero, one row a cycle, with busy high;
//   reactions_in_use resets to 64

module weighted_sum_tree_sampler #(
    parameter int NUM_REACTIONS = 64,
    parameter int PROP_WIDTH    = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire wsts_pkg::in_item_t            request,
    output logic                               done,
    output wsts_pkg::out_item_t                result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wsts_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IDX_W  = $clog2(NUM_REACTIONS);
    localparam int NW     = IDX_W + 1;
    localparam int CH_W   = IDX_W + 2;
    localparam int SUM_W  = wsts_pkg::SUM_W;
    localparam int ST_W   = wsts_pkg::START_W;
    localparam int ROW_W  = PROP_WIDTH + 2 * SUM_W;
    localparam int FR_W   = wsts_pkg::FRAC_W;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_PROP  = 14'b00000000000100,
        S_URD   = 14'b00000000001000,
        S_UPD   = 14'b00000000010000,
        S_TRD   = 14'b00000000100000,
        S_TOT   = 14'b00000001000000,
        S_MLO   = 14'b00000010000000,
        S_MHI   = 14'b00000100000000,
        S_XC    = 14'b00001000000000,
        S_WRD   = 14'b00010000000000,
        S_WSUM  = 14'b00100000000000,
        S_WDEC  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [wsts_pkg::CFG_W-1:0]   cfg_reg;
    logic [IDX_W-1:0]             clr_reg;
    logic [NW-1:0]                n_now;
    logic [NW-1:0]                n_reg;
    logic                         accept;
    logic                         in_range;

    wsts_pkg::in_item_t           req_reg;
    logic [IDX_W-1:0]             cur_reg;
    logic                         self_reg;
    logic                         side_left_reg;
    logic [PROP_WIDTH-1:0]        np_reg;
    logic [SUM_W-1:0]             diff_reg;
    logic [SUM_W-1:0]             total_reg;
    logic [2*FR_W-1:0]            mlo_reg;
    logic [ST_W-1:0]              mhi_reg;
    logic [ST_W-1:0]              x_reg;
    logic [ST_W-1:0]              start_reg;
    logic [ST_W-1:0]              s_reg;
    logic [IDX_W-1:0]             sel_reg;
    logic                         found_reg;

    // memory port
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [ROW_W-1:0]             rd_data;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [ROW_W-1:0]             wr_data;
    logic [PROP_WIDTH-1:0]        row_prop;
    logic [SUM_W-1:0]             row_left;
    logic [SUM_W-1:0]             row_right;

    // walk decision
    logic [ST_W-1:0]              sp;
    logic                         go_left;
    logic                         go_right;
    logic [CH_W-1:0]              child;

    logic                         prop_go;
    logic                         prop_ready;
    logic [PROP_WIDTH-1:0]        prop_val;

    wsts_row_mem #(
        .DEPTH  (NUM_REACTIONS),
        .WIDTH  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    wsts_prop_unit #(
        .PROP_WIDTH (PROP_WIDTH)
    ) u_prop_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (prop_go),
        .item  (request),
        .ready (prop_ready),
        .prop  (prop_val)
    );

    assign row_prop  = rd_data[ROW_W-1 -: PROP_WIDTH];
    assign row_left  = rd_data[2*SUM_W-1 -: SUM_W];
    assign row_right = rd_data[SUM_W-1:0];

    // reactions_in_use clamped to 1 .. NUM_REACTIONS
    always_comb
    begin
        if (cfg_reg == '0)
            n_now = NW'(1);
        else if (32'(cfg_reg) > 32'(NUM_REACTIONS))
            n_now = NW'(NUM_REACTIONS);
        else
            n_now = NW'(cfg_reg);
    end

    assign accept   = start && (state_reg == S_IDLE);
    assign in_range = 32'(request.reaction_index) < 32'(n_now);
    assign prop_go  = accept && (request.func == wsts_pkg::FUNC_UPDATE) && in_range;

    // one level of the downward walk
    always_comb
    begin
        sp       = s_reg + ST_W'(row_prop);
        go_left  = x_reg < s_reg;
        go_right = !go_left && (x_reg >= sp);
        if (go_left)
            child = {1'b0, cur_reg, 1'b1};
        else
            child = {1'b0, cur_reg, 1'b1} + CH_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == IDX_W'(NUM_REACTIONS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.func == wsts_pkg::FUNC_SEARCH)
                        state_next = S_TRD;
                    else if (in_range)
                        state_next = S_PROP;
                    else
                        state_next = S_TRD;
                end
            end
            S_PROP:  if (prop_ready) state_next = S_URD;
            S_URD:   state_next = S_UPD;
            S_UPD:   state_next = (cur_reg == '0) ? S_TRD : S_URD;
            S_TRD:   state_next = S_TOT;
            S_TOT:   state_next = (req_reg.func == wsts_pkg::FUNC_SEARCH) ? S_MLO : S_OUT;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_XC;
            S_XC:    state_next = S_WRD;
            S_WRD:   state_next = S_WSUM;
            S_WSUM:  state_next = S_WDEC;
            S_WDEC:
            begin
                if (!go_left && !go_right)
                    state_next = S_OUT;
                else if (child >= CH_W'(n_reg))
                    state_next = S_OUT;
                else
                    state_next = S_WRD;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory accesses: reads are issued in the state before their data is first used
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = rd_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            S_URD, S_WRD:
            begin
                rd_en = 1'b1;
            end
            S_TRD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_UPD:
            begin
                wr_en = 1'b1;
                if (self_reg)
                    wr_data = {np_reg, row_left, row_right};
                else if (side_left_reg)
                    wr_data = {row_prop, row_left + diff_reg, row_right};
                else
                    wr_data = {row_prop, row_left, row_right + diff_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cfg_reg   <= wsts_pkg::CFG_RESET;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                req_reg   <= request;
                n_reg     <= n_now;
                cur_reg   <= IDX_W'(request.reaction_index);
                self_reg  <= 1'b1;
                sel_reg   <= '0;
                found_reg <= 1'b0;
            end
            S_PROP:
            begin
                np_reg <= prop_val;
            end
            S_UPD:
            begin
                if (self_reg)
                    diff_reg <= SUM_W'(ST_W'(np_reg) - ST_W'(row_prop));
                self_reg      <= 1'b0;
                // odd node is the left child of its parent
                side_left_reg <= cur_reg[0];
                cur_reg       <= (cur_reg - IDX_W'(1)) >> 1;
            end
            S_TOT:
            begin
                total_reg <= SUM_W'(ST_W'(row_prop) + ST_W'(row_left) + ST_W'(row_right));
            end
            S_MLO:
            begin
                mlo_reg <= (2*FR_W)'(req_reg.rand_fraction) * (2*FR_W)'(total_reg[FR_W-1:0]);
            end
            S_MHI:
            begin
                mhi_reg <= ST_W'(req_reg.rand_fraction) * ST_W'(total_reg[SUM_W-1:FR_W]);
            end
            S_XC:
            begin
                x_reg     <= mhi_reg + ST_W'(mlo_reg[2*FR_W-1:FR_W]);
                start_reg <= '0;
                cur_reg   <= '0;
            end
            S_WSUM:
            begin
                s_reg <= start_reg + ST_W'(row_left);
            end
            S_WDEC:
            begin
                if (!go_left && !go_right)
                begin
                    sel_reg   <= cur_reg;
                    found_reg <= 1'b1;
                end
                else
                begin
                    cur_reg <= child[IDX_W-1:0];
                    if (go_right)
                        start_reg <= sp;
                end
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;

    assign result.selected_index   = wsts_pkg::IDX_IN_W'(sel_reg);
    assign result.found            = found_reg;
    assign result.total_propensity = total_reg;

endmodule

`default_nettype wire

// ----- design/wsts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wsts_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire wsts_pkg::out_item_t  result
);

    // a taken item keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // result strobe comes while busy and releases the block
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result while idle");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.selected_index == '0))
        else $error("index set without a hit");

endmodule

bind weighted_sum_tree_sampler wsts_checker u_wsts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ----- tb/tb_weighted_sum_tree_sampler.sv -----
`timescale 1ns / 1ps

module tb_weighted_sum_tree_sampler;

    localparam int NODES     = 64;
    localparam int PROP_BITS = 48;
    localparam int WATCHDOG  = 20000;
    localparam logic [wsts_pkg::SUM_W-1:0] SUM_MASK = {wsts_pkg::SUM_W{1'b1}};
    localparam logic [PROP_BITS-1:0] PROP_SAT = {PROP_BITS{1'b1}};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    wsts_pkg::in_item_t request;
    logic done;
    wsts_pkg::out_item_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [wsts_pkg::CFG_W-1:0] cfg_data;

    weighted_sum_tree_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state: mirror of the tree memory
    logic [PROP_BITS-1:0] prop_mirror [NODES];
    logic [wsts_pkg::SUM_W-1:0] left_mirror [NODES];
    logic [wsts_pkg::SUM_W-1:0] right_mirror [NODES];
    int unsigned nodes_in_use;

    wsts_pkg::in_item_t pending_items [$];
    wsts_pkg::out_item_t expected_results [$];
    int error_count;
    int update_count;
    int search_count;
    int found_count;
    int idle_cycles;
    bit driver_busy;

    // saturating multiply at the propensity width
    function automatic logic [63:0] sat_product(logic [63:0] a, logic [63:0] b);
        if (a == 0 || b == 0)
            return 0;
        if (a > {16'd0, PROP_SAT} / b)
            return {16'd0, PROP_SAT};
        return a * b;
    endfunction

    function automatic logic [63:0] propensity_for(wsts_pkg::in_item_t it);
        logic [63:0] factors [7];
        logic [63:0] acc;
        int nf;
        nf = 0;
        factors[nf] = 64'(it.rate);
        nf++;
        for (int i = 0; i < int'(it.coeff_first); i++) begin
            factors[nf] = (int'(it.count_first) >= i) ? 64'(int'(it.count_first) - i) : 64'd0;
            nf++;
        end
        for (int i = 0; i < int'(it.coeff_second); i++) begin
            factors[nf] = (int'(it.count_second) >= i) ? 64'(int'(it.count_second) - i)
                                                       : 64'd0;
            nf++;
        end
        for (int i = 0; i < nf; i++)
            if (factors[i] == 0)
                return 0;
        acc = 1;
        for (int i = 0; i < nf; i++)
            acc = sat_product(acc, factors[i]);
        return acc;
    endfunction

    function automatic logic [wsts_pkg::SUM_W-1:0] tree_total();
        return (prop_mirror[0] + left_mirror[0] + right_mirror[0]) & SUM_MASK;
    endfunction

    // apply one item to the mirror and return what the block should report
    function automatic wsts_pkg::out_item_t sample_tree_step(wsts_pkg::in_item_t it);
        wsts_pkg::out_item_t r;
        logic [63:0] target;
        logic [63:0] interval_lo;
        logic [63:0] tot;
        logic [wsts_pkg::SUM_W-1:0] delta;
        int unsigned node;
        int unsigned child;
        int unsigned idx;
        r = '0;
        if (it.func == wsts_pkg::FUNC_UPDATE) begin
            idx = it.reaction_index;
            if (idx < nodes_in_use) begin
                logic [63:0] np;
                np = propensity_for(it);
                delta = wsts_pkg::SUM_W'((np - 64'(prop_mirror[idx])) & 64'(SUM_MASK));
                prop_mirror[idx] = np[PROP_BITS-1:0];
                while (idx != 0) begin
                    int unsigned par;
                    par = (idx - 1) >> 1;
                    if (idx & 1)
                        left_mirror[par] = (left_mirror[par] + delta) & SUM_MASK;
                    else
                        right_mirror[par] = (right_mirror[par] + delta) & SUM_MASK;
                    idx = par;
                end
            end
        end
        else begin
            tot = 64'(tree_total());
            target = 64'(it.rand_fraction) * (tot >> 32)
                + ((64'(it.rand_fraction) * (tot & 64'hFFFF_FFFF)) >> 32);
            node = 0;
            interval_lo = 64'(left_mirror[0]);
            forever begin
                if (target < interval_lo) begin
                    interval_lo -= 64'(left_mirror[node]);
                    child = node * 2 + 1;
                end
                else if (target >= interval_lo + 64'(prop_mirror[node])) begin
                    interval_lo += 64'(prop_mirror[node]);
                    child = node * 2 + 2;
                end
                else begin
                    r.selected_index = node[5:0];
                    r.found = 1'b1;
                    break;
                end
                if (child >= nodes_in_use)
                    break;
                node = child;
                interval_lo += 64'(left_mirror[node]);
            end
        end
        r.total_propensity = tree_total();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    task automatic queue_item(wsts_pkg::in_item_t it);
        pending_items = {pending_items, it};
    endtask

    // driver: bursts with random gaps; predicts at the accepting edge
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            request <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else begin
            // an item was taken at this edge
            if (start && !busy) begin
                wsts_pkg::out_item_t e;
                e = sample_tree_step(request);
                expected_results = {expected_results, e};
                if (request.func == wsts_pkg::FUNC_UPDATE)
                    update_count++;
                else
                    search_count++;
            end
            if (start && busy) begin
                // hold the item until taken
            end
            else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_items.size() != 0 && driver_busy) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 25);
                end
                if (gap_left > 0) begin
                    start <= 1'b0;
                end
                else begin
                    request <= pending_items.pop_front();
                    start <= 1'b1;
                    burst_left--;
                end
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, so every done cycle is checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'd1, 64'd0);
                end
                else begin
                    wsts_pkg::out_item_t e;
                    e = expected_results.pop_front();
                    if (result.selected_index !== e.selected_index)
                        report_mismatch("selected_index", 64'(result.selected_index),
                            64'(e.selected_index));
                    if (result.found !== e.found)
                        report_mismatch("found", 64'(result.found), 64'(e.found));
                    if (result.total_propensity !== e.total_propensity)
                        report_mismatch("total_propensity", 64'(result.total_propensity),
                            64'(e.total_propensity));
                    if (e.found)
                        found_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired, %0d results outstanding", expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic wsts_pkg::in_item_t update_item(int idx, logic [31:0] rt,
        logic [15:0] c1, logic [1:0] k1, logic [15:0] c2, logic [1:0] k2);
        wsts_pkg::in_item_t it;
        it = '0;
        it.func = wsts_pkg::FUNC_UPDATE;
        it.reaction_index = wsts_pkg::IDX_IN_W'(idx);
        it.rand_fraction = $urandom;
        it.rate = rt;
        it.count_first = c1;
        it.coeff_first = k1;
        it.count_second = c2;
        it.coeff_second = k2;
        return it;
    endfunction

    function automatic wsts_pkg::in_item_t search_item(logic [31:0] frac);
        wsts_pkg::in_item_t it;
        it = '0;
        it.func = wsts_pkg::FUNC_SEARCH;
        it.reaction_index = wsts_pkg::IDX_IN_W'($urandom);
        it.rand_fraction = frac;
        it.rate = $urandom;
        it.count_first = 16'($urandom);
        it.coeff_first = 2'($urandom);
        it.count_second = 16'($urandom);
        it.coeff_second = 2'($urandom);
        return it;
    endfunction

    // mostly small realistic propensities, sometimes extremes
    function automatic wsts_pkg::in_item_t random_update(int max_idx);
        logic [31:0] rt;
        logic [15:0] c1;
        logic [15:0] c2;
        case ($urandom_range(0, 5))
            0: rt = $urandom;
            1: rt = 32'hFFFF_FFFF;
            default: rt = $urandom_range(0, 32'h0004_0000);
        endcase
        c1 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        c2 = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if ($urandom_range(0, 15) == 0)
            rt = 0;
        return update_item(int'($urandom_range(0, max_idx)), rt, c1, 2'($urandom), c2,
            2'($urandom));
    endfunction

    // wait until every item is taken and every result is back
    task automatic drain();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_config(logic [wsts_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        nodes_in_use = (value == 0) ? 1 : (int'(value) > NODES ? NODES : int'(value));
    endtask

    task automatic run_phase(int count, int max_idx);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0)
                queue_item(random_update(max_idx));
            else
                queue_item(search_item($urandom));
        end
        driver_busy = 1'b1;
        drain();
    endtask

    initial
    begin
        logic [wsts_pkg::CFG_W-1:0] settings [6];
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        update_count = 0;
        search_count = 0;
        found_count = 0;
        idle_cycles = 0;
        driver_busy = 1'b0;
        nodes_in_use = NODES;
        for (int i = 0; i < NODES; i++) begin
            prop_mirror[i] = '0;
            left_mirror[i] = '0;
            right_mirror[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero tree, extremes, saturation, short counts
        queue_item(search_item(32'h0));
        queue_item(update_item(0, 32'h0001_0000, 16'd5, 2'd1, 16'd0, 2'd0));
        queue_item(update_item(63, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 16'hFFFF, 2'd3));
        queue_item(update_item(1, 32'h0002_0000, 16'd1, 2'd2, 16'd3, 2'd1));
        queue_item(update_item(2, 32'h0000_8000, 16'd10, 2'd3, 16'd7, 2'd2));
        queue_item(update_item(5, 32'h0, 16'd9, 2'd1, 16'd9, 2'd1));
        queue_item(update_item(6, 32'h0000_0001, 16'd0, 2'd0, 16'd0, 2'd0));
        queue_item(search_item(32'h0));
        queue_item(search_item(32'hFFFF_FFFF));
        queue_item(search_item(32'h8000_0000));
        queue_item(update_item(63, 32'h0, 16'd0, 2'd0, 16'd0, 2'd0));
        queue_item(search_item(32'hFFFF_FFFF));
        queue_item(search_item(32'h4000_0000));
        driver_busy = 1'b1;
        drain();

        // shrink to one node: out-of-range updates and missing children
        write_config(7'd0);
        queue_item(update_item(3, 32'h0001_0000, 16'd2, 2'd1, 16'd0, 2'd0));
        queue_item(update_item(0, 32'h0003_0000, 16'd2, 2'd1, 16'd0, 2'd0));
        queue_item(search_item(32'hFFFF_FFFF));
        queue_item(search_item(32'h0));
        drain();

        settings = '{7'd64, 7'd1, 7'd127, 7'd37, 7'd2, 7'd64};
        foreach (settings[s]) begin
            write_config(settings[s]);
            run_phase(235, (s == 2) ? 63 : int'($urandom_range(0, 63)));
        end

        $display("updates %0d, searches %0d (%0d landed, %0d fell out), six register settings",
            update_count, search_count, found_count, search_count - found_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/wsts_pkg.sv
design/wsts_row_mem.sv
design/wsts_prop_unit.sv
design/weighted_sum_tree_sampler.sv
design/wsts_checker.sv
tb/tb_weighted_sum_tree_sampler.sv
